### sv/suffix_automaton_builder_query_unit_assert.svh
// assertion macros used by the checker file
`ifndef SUFFIX_AUTOMATON_BUILDER_QUERY_UNIT_ASSERT_SVH
`define SUFFIX_AUTOMATON_BUILDER_QUERY_UNIT_ASSERT_SVH

// same-cycle implication
`define SAQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SAQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/saq_pkg.sv
package saq_pkg;

    localparam int MAX_TEXT_DEF    = 256;
    localparam int SYMBOL_BITS_DEF = 8;
    // generation tag kept in each transition entry
    localparam int EPOCH_W         = 4;
    // width of reported positions
    localparam int POS_W           = 8;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

endpackage

### sv/saq_trans_mem.sv
module saq_trans_mem
    import saq_pkg::*;
#(
    parameter int ADDR_W = 17,
    parameter int DATA_W = 13
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(2**ADDR_W)-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/saq_state_mem.sv
module saq_state_mem
    import saq_pkg::*;
#(
    parameter int ADDR_W = 9,
    parameter int DATA_W = 26
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(2**ADDR_W)-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/suffix_automaton_builder_query_unit.sv
// Online suffix automaton with a streaming substring query. One transaction in
// gives one transaction out, and the input stays closed until the result sits in
// the output register; s_tready rises on the edge that loads it there. A query
// symbol reads the transition table and, when the transition exists, then reads
// the target state's first end position; once the walk has failed, the symbol
// goes straight to the result. An append walks the suffix links, reading the
// table for each state visited, and compares lengths when the walk stops on an
// existing transition. A clone copies the transition row entry by entry through
// the table ports, then checks states while redirecting their transitions to the
// clone. A stalled output holds the result back until it is taken. The transition
// table is swept to zero after reset and after every 2^4-th clear, with s_tready
// low; other clears only bump a generation tag held in each table entry.
module suffix_automaton_builder_query_unit
    import saq_pkg::*;
#(
    parameter int MAX_TEXT    = MAX_TEXT_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // symbol
    input  logic [1:0]  s_tuser,   // opcode
    input  logic        s_tlast,   // query_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status, found, first_position[7:0], zero fill
    output logic        m_tlast    // query_done
);

    localparam int NSTATES = 2 * MAX_TEXT;
    localparam int IDX_W   = $clog2(NSTATES);
    localparam int LEN_W   = $clog2(MAX_TEXT + 1);
    localparam int TADDR_W = IDX_W + SYMBOL_BITS;
    localparam int ENT_W   = IDX_W + EPOCH_W;
    localparam int SW_W    = LEN_W + IDX_W + POS_W;
    localparam int CPY_W   = SYMBOL_BITS + 1;

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_CLR   = 14'b00000000000010,
        ST_A_RD  = 14'b00000000000100,
        ST_A_CHK = 14'b00000000001000,
        ST_A_CMP = 14'b00000000010000,
        ST_C_CL  = 14'b00000000100000,
        ST_C_CPY = 14'b00000001000000,
        ST_R_RD  = 14'b00000010000000,
        ST_R_CHK = 14'b00000100000000,
        ST_A_FIN = 14'b00001000000000,
        ST_Q_RD  = 14'b00010000000000,
        ST_Q_CHK = 14'b00100000000000,
        ST_Q_POS = 14'b01000000000000,
        ST_DONE  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [TADDR_W-1:0]     clr_idx_reg, clr_idx_next;
    logic                   clr_res_reg, clr_res_next;
    logic [EPOCH_W-1:0]     epoch_reg, epoch_next;
    logic [IDX_W-1:0]       cnt_reg, cnt_next;
    logic [IDX_W-1:0]       last_reg, last_next;
    logic [LEN_W-1:0]       last_len_reg, last_len_next;
    logic [LEN_W-1:0]       tlen_reg, tlen_next;
    logic [IDX_W-1:0]       qstate_reg, qstate_next;
    logic [LEN_W-1:0]       qlen_reg, qlen_next;
    logic                   qfail_reg, qfail_next;

    logic [SYMBOL_BITS-1:0] sym_reg, sym_next;
    logic                   qend_reg, qend_next;
    logic [IDX_W-1:0]       cur_reg, cur_next;
    logic [LEN_W-1:0]       cur_len_reg, cur_len_next;
    logic [POS_W-1:0]       cur_fe_reg, cur_fe_next;
    logic [IDX_W-1:0]       cur_link_reg, cur_link_next;
    logic [IDX_W-1:0]       p_reg, p_next;
    logic [LEN_W-1:0]       len_p_reg, len_p_next;
    logic [IDX_W-1:0]       q_reg, q_next;
    logic [IDX_W-1:0]       cl_reg, cl_next;
    logic [IDX_W-1:0]       cl_link_reg, cl_link_next;
    logic [POS_W-1:0]       cl_fe_reg, cl_fe_next;
    logic [CPY_W-1:0]       cpy_reg, cpy_next;

    logic                   res_status_reg, res_status_next;
    logic                   res_found_reg, res_found_next;
    logic [POS_W-1:0]       res_pos_reg, res_pos_next;
    logic                   res_done_reg, res_done_next;

    logic                   m_valid_reg, m_valid_next;
    logic                   m_status_reg, m_status_next;
    logic                   m_found_reg, m_found_next;
    logic [POS_W-1:0]       m_pos_reg, m_pos_next;
    logic                   m_last_reg, m_last_next;

    logic                   t_we;
    logic [TADDR_W-1:0]     t_waddr, t_raddr;
    logic [ENT_W-1:0]       t_wdata, t_rdata;
    logic                   s_we;
    logic [IDX_W-1:0]       s_waddr, s_raddr;
    logic [SW_W-1:0]        s_wdata, s_rdata;

    logic [IDX_W-1:0]       ent_tgt;
    logic                   ent_ok;
    logic [LEN_W-1:0]       sw_len;
    logic [IDX_W-1:0]       sw_link;
    logic [POS_W-1:0]       sw_fe;
    logic [LEN_W-1:0]       len_p;

    saq_trans_mem #(.ADDR_W(TADDR_W), .DATA_W(ENT_W)) u_trans (
        .aclk (aclk),
        .we   (t_we),
        .waddr(t_waddr),
        .wdata(t_wdata),
        .raddr(t_raddr),
        .rdata(t_rdata)
    );

    saq_state_mem #(.ADDR_W(IDX_W), .DATA_W(SW_W)) u_state (
        .aclk (aclk),
        .we   (s_we),
        .waddr(s_waddr),
        .wdata(s_wdata),
        .raddr(s_raddr),
        .rdata(s_rdata)
    );

    // an entry counts only if it was written in the current generation
    assign ent_tgt = t_rdata[IDX_W-1:0];
    assign ent_ok  = (ent_tgt != '0) && (t_rdata[ENT_W-1:IDX_W] == epoch_reg);
    assign sw_len  = s_rdata[SW_W-1:IDX_W+POS_W];
    assign sw_link = s_rdata[IDX_W+POS_W-1:POS_W];
    assign sw_fe   = s_rdata[POS_W-1:0];
    // the root is never written, its length is zero
    assign len_p   = (p_reg == '0) ? '0 : sw_len;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(16 - POS_W - 2){1'b0}}, m_pos_reg, m_found_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

    always_comb begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        clr_res_next    = clr_res_reg;
        epoch_next      = epoch_reg;
        cnt_next        = cnt_reg;
        last_next       = last_reg;
        last_len_next   = last_len_reg;
        tlen_next       = tlen_reg;
        qstate_next     = qstate_reg;
        qlen_next       = qlen_reg;
        qfail_next      = qfail_reg;
        sym_next        = sym_reg;
        qend_next       = qend_reg;
        cur_next        = cur_reg;
        cur_len_next    = cur_len_reg;
        cur_fe_next     = cur_fe_reg;
        cur_link_next   = cur_link_reg;
        p_next          = p_reg;
        len_p_next      = len_p_reg;
        q_next          = q_reg;
        cl_next         = cl_reg;
        cl_link_next    = cl_link_reg;
        cl_fe_next      = cl_fe_reg;
        cpy_next        = cpy_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_pos_next    = res_pos_reg;
        res_done_next   = res_done_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_found_next    = m_found_reg;
        m_pos_next      = m_pos_reg;
        m_last_next     = m_last_reg;

        t_we    = 1'b0;
        t_waddr = {p_reg, sym_reg};
        t_wdata = {epoch_reg, cur_reg};
        t_raddr = {p_reg, sym_reg};
        s_we    = 1'b0;
        s_waddr = cur_reg;
        s_wdata = {cur_len_reg, cur_link_reg, cur_fe_reg};
        s_raddr = p_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    sym_next        = s_tdata[SYMBOL_BITS-1:0];
                    qend_next       = s_tlast;
                    res_status_next = 1'b0;
                    res_found_next  = 1'b0;
                    res_pos_next    = '0;
                    res_done_next   = 1'b0;
                    state_next      = ST_DONE;
                    case (opcode_t'(s_tuser))
                        OP_APPEND: begin
                            if (tlen_reg == LEN_W'(MAX_TEXT)) begin
                                res_status_next = 1'b1;
                            end else begin
                                cur_next     = cnt_reg;
                                cnt_next     = cnt_reg + 1'b1;
                                cur_len_next = last_len_reg + 1'b1;
                                cur_fe_next  = POS_W'(last_len_reg);
                                p_next       = last_reg;
                                state_next   = ST_A_RD;
                            end
                        end
                        OP_QUERY: begin
                            res_done_next = s_tlast;
                            if (!qfail_reg) begin
                                state_next = ST_Q_RD;
                            end else if (s_tlast) begin
                                qstate_next = '0;
                                qlen_next   = '0;
                                qfail_next  = 1'b0;
                            end
                        end
                        OP_CLEAR: begin
                            epoch_next    = epoch_reg + 1'b1;
                            cnt_next      = IDX_W'(1);
                            last_next     = '0;
                            last_len_next = '0;
                            tlen_next     = '0;
                            qstate_next   = '0;
                            qlen_next     = '0;
                            qfail_next    = 1'b0;
                            // tag wrapped, stale entries could look current
                            if (epoch_reg == {EPOCH_W{1'b1}}) begin
                                clr_idx_next = '0;
                                clr_res_next = 1'b1;
                                state_next   = ST_CLR;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CLR: begin
                t_we         = 1'b1;
                t_waddr      = clr_idx_reg;
                t_wdata      = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == {TADDR_W{1'b1}}) begin
                    state_next = clr_res_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_A_RD: begin
                state_next = ST_A_CHK;
            end
            ST_A_CHK: begin
                if (!ent_ok) begin
                    t_we = 1'b1;
                    if (p_reg == '0) begin
                        cur_link_next = '0;
                        state_next    = ST_A_FIN;
                    end else begin
                        p_next     = sw_link;
                        state_next = ST_A_RD;
                    end
                end else begin
                    q_next     = ent_tgt;
                    s_raddr    = ent_tgt;
                    len_p_next = len_p;
                    state_next = ST_A_CMP;
                end
            end
            ST_A_CMP: begin
                if (sw_len == len_p_reg + 1'b1) begin
                    cur_link_next = q_reg;
                    state_next    = ST_A_FIN;
                end else begin
                    cl_next       = cnt_reg;
                    cnt_next      = cnt_reg + 1'b1;
                    cl_link_next  = sw_link;
                    cl_fe_next    = sw_fe;
                    cur_link_next = cnt_reg;
                    s_we          = 1'b1;
                    s_waddr       = q_reg;
                    s_wdata       = {sw_len, cnt_reg, sw_fe};
                    state_next    = ST_C_CL;
                end
            end
            ST_C_CL: begin
                s_we       = 1'b1;
                s_waddr    = cl_reg;
                s_wdata    = {len_p_reg + 1'b1, cl_link_reg, cl_fe_reg};
                cpy_next   = '0;
                state_next = ST_C_CPY;
            end
            ST_C_CPY: begin
                // read entry i of q while entry i-1 goes into the clone
                t_raddr  = {q_reg, cpy_reg[SYMBOL_BITS-1:0]};
                t_waddr  = {cl_reg, SYMBOL_BITS'(cpy_reg - 1'b1)};
                t_wdata  = ent_ok ? {epoch_reg, ent_tgt} : '0;
                t_we     = (cpy_reg != '0);
                cpy_next = cpy_reg + 1'b1;
                if (cpy_reg[SYMBOL_BITS]) begin
                    state_next = ST_R_RD;
                end
            end
            ST_R_RD: begin
                state_next = ST_R_CHK;
            end
            ST_R_CHK: begin
                if (ent_ok && (ent_tgt == q_reg)) begin
                    t_we    = 1'b1;
                    t_wdata = {epoch_reg, cl_reg};
                    if (p_reg == '0) begin
                        state_next = ST_A_FIN;
                    end else begin
                        p_next     = sw_link;
                        state_next = ST_R_RD;
                    end
                end else begin
                    state_next = ST_A_FIN;
                end
            end
            ST_A_FIN: begin
                s_we          = 1'b1;
                last_next     = cur_reg;
                last_len_next = cur_len_reg;
                tlen_next     = tlen_reg + 1'b1;
                state_next    = ST_DONE;
            end
            ST_Q_RD: begin
                t_raddr    = {qstate_reg, sym_reg};
                state_next = ST_Q_CHK;
            end
            ST_Q_CHK: begin
                if (!ent_ok) begin
                    qfail_next = !qend_reg;
                    if (qend_reg) begin
                        qstate_next = '0;
                        qlen_next   = '0;
                    end
                    state_next = ST_DONE;
                end else begin
                    q_next     = ent_tgt;
                    s_raddr    = ent_tgt;
                    state_next = ST_Q_POS;
                end
            end
            ST_Q_POS: begin
                res_found_next = 1'b1;
                res_pos_next   = sw_fe - POS_W'(qlen_reg);
                if (qend_reg) begin
                    qstate_next = '0;
                    qlen_next   = '0;
                end else begin
                    qstate_next = q_reg;
                    qlen_next   = qlen_reg + 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_found_next  = res_found_reg;
                    m_pos_next    = res_pos_reg;
                    m_last_next   = res_done_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            clr_idx_reg  <= '0;
            clr_res_reg  <= 1'b0;
            epoch_reg    <= '0;
            cnt_reg      <= IDX_W'(1);
            last_reg     <= '0;
            last_len_reg <= '0;
            tlen_reg     <= '0;
            qstate_reg   <= '0;
            qlen_reg     <= '0;
            qfail_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            clr_res_reg  <= clr_res_next;
            epoch_reg    <= epoch_next;
            cnt_reg      <= cnt_next;
            last_reg     <= last_next;
            last_len_reg <= last_len_next;
            tlen_reg     <= tlen_next;
            qstate_reg   <= qstate_next;
            qlen_reg     <= qlen_next;
            qfail_reg    <= qfail_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg        <= sym_next;
        qend_reg       <= qend_next;
        cur_reg        <= cur_next;
        cur_len_reg    <= cur_len_next;
        cur_fe_reg     <= cur_fe_next;
        cur_link_reg   <= cur_link_next;
        p_reg          <= p_next;
        len_p_reg      <= len_p_next;
        q_reg          <= q_next;
        cl_reg         <= cl_next;
        cl_link_reg    <= cl_link_next;
        cl_fe_reg      <= cl_fe_next;
        cpy_reg        <= cpy_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_pos_reg    <= res_pos_next;
        res_done_reg   <= res_done_next;
        m_status_reg   <= m_status_next;
        m_found_reg    <= m_found_next;
        m_pos_reg      <= m_pos_next;
        m_last_reg     <= m_last_next;
    end

endmodule

### sv/saq_checker.sv
`include "suffix_automaton_builder_query_unit_assert.svh"

module saq_checker
    import saq_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // table sweep keeps the input closed right after reset
    `SAQ_ASSERT_NXT(a_reset_closed, aclk, 1'b1, !aresetn, !s_tready, "input open after reset")
    // one transaction in flight at a time
    `SAQ_ASSERT_NXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second item taken")
    `SAQ_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped")
    `SAQ_ASSERT_NXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "result changed")

endmodule

bind suffix_automaton_builder_query_unit saq_checker u_saq_checker (.*);
